[hw/rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Codes, field widths and cell constants of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Item kind carried in s_tuser.
  typedef enum logic {
    OP_PUT  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Field widths of the stream items.
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 11;
  localparam int OCOL_W   = 7;
  localparam int OROW_W   = 5;
  localparam int OLOC_W   = 11;
  localparam int CELL_DW  = 16;
  localparam int ATTR_W   = 8;
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 40;

  // Character codes with a cursor action of their own.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

  localparam logic [CELL_DW-1:0] BLANK_CELL  = 16'h0020;
  localparam logic [ATTR_W-1:0]  ATTR_RESET  = 8'd15;

endpackage

[hw/rtl/text_console_char_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Teletype engine over a ROWS x COLUMNS text cell memory with cursor tracking.
// ----------------------------------------------------------------------------
// Puts pass the char state; printable bytes then address and write states, after
// a further char pass for a pending wrap, and sweep a blanked row through the single
// write port on its first write. Reads pass divide (reciprocal row multiply), map,
// address, memory read and wait states, or skip to done off screen. One item is in
// flight; the next is taken once its result is registered. Reset clears cursor,
// scroll offset and row valid bits (rows read blank, no clearing pass); attr 15.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_DW-1:0]  s_tdata,   // char_code[7:0], cell_address[18:8]
  input  logic [0:0]        s_tuser,   // op[0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_DW-1:0] m_tdata,   // cursor_column[6:0], cursor_row[11:7],
                                       // cursor_location[22:12], cell_data[38:23]
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ATTR_W-1:0] cfg_data
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS + 1);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int TAB_COUNT  = COLUMNS / TAB_STOP + 1;
  localparam int DIV_SH     = CELL_W + $clog2(COLUMNS);
  localparam int DIV_PW     = 2 * CELL_W + 2;
  localparam logic [DIV_PW-1:0] DIV_RECIP = DIV_PW'((2 ** DIV_SH + COLUMNS - 1) / COLUMNS);
  localparam logic [COL_W-1:0]  COL_END  = COL_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHAR,
    S_DIV,
    S_MAP,
    S_ADDR,
    S_WRITE,
    S_RD,
    S_RWAIT,
    S_DONE
  } state_t;

  state_t               state;
  op_t                  op_r;
  logic [CHAR_W-1:0]    char_r;
  logic [ATTR_W-1:0]    attr;
  logic [COL_W-1:0]     col;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     top;
  logic [ROWS-1:0]      row_valid;
  logic [ROW_W-1:0]     prow;
  logic [CELL_W-1:0]    base;
  logic [COL_W-1:0]     col_sel;
  logic [COL_W-1:0]     sweep;
  logic [CELL_W-1:0]    rem;
  logic [ROW_W-1:0]     quo;
  logic [CELL_DW-1:0]   data;
  logic [OCOL_W-1:0]    out_col;
  logic [OROW_W-1:0]    out_row;
  logic [OLOC_W-1:0]    out_loc;
  logic [CELL_DW-1:0]   out_data;

  logic [CELL_DW-1:0]   mem [CELL_COUNT];
  logic [CELL_DW-1:0]   rd_data;
  logic                 mem_we;
  logic                 mem_re;
  logic [CELL_W-1:0]    mem_waddr;
  logic [CELL_W-1:0]    mem_raddr;
  logic [CELL_DW-1:0]   mem_wdata;

  logic [CELL_DW-1:0]   put_cell;
  logic [ROW_W-1:0]     top_inc;
  logic                 at_bottom;
  logic [ROW_W-1:0]     map_src;
  logic [ROW_W:0]       map_sum;
  logic [ROW_W-1:0]     map_row;
  logic [DIV_PW-1:0]    div_prod;
  logic [ROW_W-1:0]     div_quo;

  // Next tab stop above column c, held at COLUMNS.
  function automatic logic [COL_W-1:0] tab_target(input logic [COL_W-1:0] c);
    int cand;
    cand = COLUMNS;
    for (int k = TAB_COUNT; k >= 1; k--) begin
      if (k * TAB_STOP > int'(c)) cand = k * TAB_STOP;
    end
    if (cand > COLUMNS) cand = COLUMNS;
    return COL_W'(cand);
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = {1'b0, out_data, out_loc, out_row, out_col};

  assign put_cell  = {attr, char_r};
  assign at_bottom = (row == ROW_LAST);
  assign top_inc   = (top == ROW_LAST) ? '0 : top + 1'b1;

  // Row of a cell address by reciprocal multiplication; exact over the whole screen.
  assign div_prod  = DIV_PW'(rem) * DIV_RECIP;
  assign div_quo   = div_prod[DIV_SH +: ROW_W];

  // Logical row to physical row of the row ring; the top row moves on scroll.
  always_comb begin
    map_src = (state == S_MAP) ? quo : row;
    map_sum = {1'b0, top} + {1'b0, map_src};
    if (map_sum >= (ROW_W + 1)'(ROWS)) map_sum = map_sum - (ROW_W + 1)'(ROWS);
    map_row = map_sum[ROW_W-1:0];
  end

  // A row that is not valid is swept with blanks on its first write.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = (state == S_RD);
    mem_raddr = base + CELL_W'(col_sel);
    mem_waddr = base + CELL_W'(col_sel);
    mem_wdata = put_cell;
    if (state == S_WRITE) begin
      mem_we = 1'b1;
      if (!row_valid[prow]) begin
        mem_waddr = base + CELL_W'(sweep);
        mem_wdata = (sweep == col_sel) ? put_cell : BLANK_CELL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      attr      <= ATTR_RESET;
      col       <= '0;
      row       <= '0;
      top       <= '0;
      row_valid <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) attr <= cfg_data;
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_r   <= op_t'(s_tuser[0]);
            char_r <= s_tdata[CHAR_W-1:0];
            data   <= '0;
            rem    <= CELL_W'(s_tdata[CHAR_W +: ADDR_W]);
            quo    <= '0;
            if (op_t'(s_tuser[0]) == OP_PUT) begin
              state <= S_CHAR;
            end else if (int'(s_tdata[CHAR_W +: ADDR_W]) < CELL_COUNT) begin
              state <= S_DIV;
            end else begin
              state <= S_DONE;
            end
          end
        end

        S_CHAR: begin
          if (char_r == CH_BACKSPACE) begin
            if (col != '0) col <= col - 1'b1;
            state <= S_DONE;
          end else if (col == COL_END) begin
            // Pending wrap goes first; the byte is handled on the next pass.
            col <= '0;
            if (at_bottom) begin
              top            <= top_inc;
              row_valid[top] <= 1'b0;
            end else begin
              row <= row + 1'b1;
            end
          end else if (char_r == CH_TAB) begin
            col   <= tab_target(col);
            state <= S_DONE;
          end else if (char_r == CH_NEWLINE) begin
            col <= '0;
            if (at_bottom) begin
              top            <= top_inc;
              row_valid[top] <= 1'b0;
            end else begin
              row <= row + 1'b1;
            end
            state <= S_DONE;
          end else if (char_r == CH_RETURN) begin
            col   <= '0;
            state <= S_DONE;
          end else if (char_r >= CH_PRINT_LO && char_r <= CH_PRINT_HI) begin
            prow    <= map_row;
            col_sel <= col;
            state   <= S_ADDR;
          end else begin
            state <= S_DONE;
          end
        end

        S_DIV: begin
          quo   <= div_quo;
          state <= S_MAP;
        end

        S_MAP: begin
          prow    <= map_row;
          col_sel <= COL_W'(rem - CELL_W'(quo * COLUMNS));
          state   <= S_ADDR;
        end

        S_ADDR: begin
          base  <= CELL_W'(prow * COLUMNS);
          sweep <= '0;
          state <= (op_r == OP_PUT) ? S_WRITE : S_RD;
        end

        S_WRITE: begin
          if (row_valid[prow]) begin
            col   <= col + 1'b1;
            state <= S_DONE;
          end else begin
            sweep <= sweep + 1'b1;
            if (sweep == COL_LAST) begin
              row_valid[prow] <= 1'b1;
              col             <= col + 1'b1;
              state           <= S_DONE;
            end
          end
        end

        S_RD: begin
          state <= S_RWAIT;
        end

        S_RWAIT: begin
          data  <= row_valid[prow] ? rd_data : BLANK_CELL;
          state <= S_DONE;
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_col  <= OCOL_W'(col);
            out_row  <= OROW_W'(row);
            out_loc  <= OLOC_W'(row * COLUMNS + col);
            out_data <= data;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
